@@ rtl/tes_pkg.sv @@
// Package of shared types, constants and helpers for the thermal erosion sweep block.
package tes_pkg;

   localparam int MAX_SIDE    = 64;
   localparam int HEIGHT_BITS = 16;
   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int INDEX_BITS  = $clog2(STORE_DEPTH);

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_SWEEP = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [0:0] REG_GRID_SIDE = 1'd0;
   localparam logic [0:0] REG_TALUS     = 1'd1;

   localparam logic [1:0] OFF_NEG  = 2'd0;
   localparam logic [1:0] OFF_ZERO = 2'd1;
   localparam logic [1:0] OFF_POS  = 2'd2;

   // Reciprocal of five scaled by 2^18, exact for 16-bit dividends.
   localparam logic [17:0] RECIP_FIVE = 18'd52429;

   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] cell_index;
      logic [15:0] height_in;
   } req_type;

   typedef struct packed {
      logic [15:0] height_out;
      logic        sweep_done;
   } rsp_type;

   typedef struct packed {
      logic ld_write;
      logic rd_issue;
      logic out_zero;
      logic out_read;
      logic out_done;
      logic sweep_init;
      logic c_read;
      logic c_cap;
      logic n_skip;
      logic n_read;
      logic n_eval;
      logic calc;
      logic c_write;
      logic div_start;
      logic div_step;
      logic n_write;
      logic cell_next;
   } cmd_type;

   typedef struct packed {
      logic side_zero;
      logic nb_in;
      logic j_end;
      logic cnt_zero;
      logic k_last;
      logic div_done;
      logic last_cell;
   } status_type;

   function automatic logic [1:0] nb_dy(input logic [3:0] j);
      logic [1:0] r;
      case (j)
         4'd0, 4'd1, 4'd2: r = OFF_NEG;
         4'd3, 4'd4:       r = OFF_ZERO;
         default:          r = OFF_POS;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] nb_dx(input logic [3:0] j);
      logic [1:0] r;
      case (j)
         4'd0, 4'd3, 4'd5: r = OFF_NEG;
         4'd1, 4'd6:       r = OFF_ZERO;
         default:          r = OFF_POS;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/tes_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tes_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/tes_ctrl.sv @@
// Controller state machine that sequences operations and the erosion sweep.
module tes_ctrl import tes_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   input  logic       out_busy,
   input  status_type status,
   output logic       req_stall,
   output cmd_type    cmd
);
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_RD_WT   = 4'd1;
   localparam logic [3:0] S_C_RD    = 4'd2;
   localparam logic [3:0] S_C_WT    = 4'd3;
   localparam logic [3:0] S_N_SEL   = 4'd4;
   localparam logic [3:0] S_N_WT    = 4'd5;
   localparam logic [3:0] S_CALC    = 4'd6;
   localparam logic [3:0] S_C_WR    = 4'd7;
   localparam logic [3:0] S_DIV_LD  = 4'd8;
   localparam logic [3:0] S_DIV_RUN = 4'd9;
   localparam logic [3:0] S_N_WR    = 4'd10;
   localparam logic [3:0] S_NEXT    = 4'd11;
   localparam logic [3:0] S_FIN     = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE) || out_busy;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_LOAD: begin
                     cmd.ld_write = 1'b1;
                     cmd.out_zero = 1'b1;
                  end
                  OP_SWEEP: begin
                     if (status.side_zero) begin
                        cmd.out_done = 1'b1;
                     end else begin
                        cmd.sweep_init = 1'b1;
                        state_in = S_C_RD;
                     end
                  end
                  OP_READ: begin
                     cmd.rd_issue = 1'b1;
                     state_in = S_RD_WT;
                  end
                  default: cmd.out_zero = 1'b1;
               endcase
            end
         end
         S_RD_WT: begin
            cmd.out_read = 1'b1;
            state_in = S_IDLE;
         end
         S_C_RD: begin
            cmd.c_read = 1'b1;
            state_in = S_C_WT;
         end
         S_C_WT: begin
            cmd.c_cap = 1'b1;
            state_in = S_N_SEL;
         end
         S_N_SEL: begin
            if (status.j_end) begin
               state_in = status.cnt_zero ? S_NEXT : S_CALC;
            end else if (status.nb_in) begin
               cmd.n_read = 1'b1;
               state_in = S_N_WT;
            end else begin
               cmd.n_skip = 1'b1;
            end
         end
         S_N_WT: begin
            cmd.n_eval = 1'b1;
            state_in = S_N_SEL;
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_C_WR;
         end
         S_C_WR: begin
            cmd.c_write = 1'b1;
            state_in = S_DIV_LD;
         end
         S_DIV_LD: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV_RUN;
         end
         S_DIV_RUN: begin
            if (status.div_done) begin
               state_in = S_N_WR;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_N_WR: begin
            cmd.n_write = 1'b1;
            state_in = status.k_last ? S_NEXT : S_DIV_LD;
         end
         S_NEXT: begin
            if (status.last_cell) begin
               state_in = S_FIN;
            end else begin
               cmd.cell_next = 1'b1;
               state_in = S_C_RD;
            end
         end
         S_FIN: begin
            cmd.out_done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

@@ rtl/tes_dp.sv @@
// Datapath with the height store, neighbor scan, share divider and result register.
module tes_dp import tes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wr_data,
   input  cmd_type     cmd,
   input  logic        rsp_stall,
   output status_type  status,
   output logic        out_busy,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);
   logic [6:0]  grid_side_ff;
   logic [15:0] talus_ff;
   logic [6:0]  side;
   logic [5:0]  row_ff, col_ff;
   logic [3:0]  j_ff;
   logic [3:0]  cnt_ff;
   logic [2:0]  k_ff;
   logic [15:0] hc_ff;
   logic [15:0] dmax_ff;
   logic [18:0] dtot_ff;
   logic [13:0] amount_ff;
   logic [11:0] nb_idx_ff [8];
   logic [15:0] nb_d_ff [8];
   logic [29:0] p_ff;
   logic [18:0] rem_ff;
   logic [15:0] q_ff;
   logic [4:0]  dcnt_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [11:0] cur_addr, nb_addr;
   logic [6:0]  nr, nc;
   logic [1:0]  dy, dx;
   logic        row_ok, col_ok;
   logic [15:0] rd_data;
   logic        wr_en, rd_en;
   logic [11:0] wr_addr, rd_addr;
   logic [15:0] wr_data;
   logic [15:0] d;
   logic        take;
   logic [31:0] amt_prod;
   logic [19:0] trial;
   logic [19:0] diff;
   logic [15:0] hn;
   logic [16:0] nh;

   assign side = (grid_side_ff > 7'(MAX_SIDE)) ? 7'(MAX_SIDE) : grid_side_ff;
   assign cur_addr = 12'({1'b0, row_ff} * side + {1'b0, col_ff});

   assign dy = nb_dy(j_ff);
   assign dx = nb_dx(j_ff);
   always_comb begin
      row_ok = 1'b1;
      col_ok = 1'b1;
      nr = {1'b0, row_ff};
      nc = {1'b0, col_ff};
      if (dy == OFF_NEG) begin
         row_ok = (row_ff != 6'd0);
         nr = {1'b0, row_ff} - 7'd1;
      end else if (dy == OFF_POS) begin
         row_ok = ({1'b0, row_ff} + 7'd1) < side;
         nr = {1'b0, row_ff} + 7'd1;
      end
      if (dx == OFF_NEG) begin
         col_ok = (col_ff != 6'd0);
         nc = {1'b0, col_ff} - 7'd1;
      end else if (dx == OFF_POS) begin
         col_ok = ({1'b0, col_ff} + 7'd1) < side;
         nc = {1'b0, col_ff} + 7'd1;
      end
   end
   assign nb_addr = 12'(nr * side + nc);

   assign d    = hc_ff - rd_data;
   assign take = (hc_ff > rd_data) && (d > talus_ff);
   assign amt_prod = {16'd0, 16'(dmax_ff - talus_ff)} * {14'd0, RECIP_FIVE};
   assign trial = {rem_ff, p_ff[29]};
   assign diff  = trial - {1'b0, dtot_ff};
   assign hn = hc_ff - nb_d_ff[k_ff];
   assign nh = {1'b0, hn} + {1'b0, q_ff};

   always_comb begin
      wr_en   = cmd.ld_write || cmd.c_write || cmd.n_write;
      wr_addr = req_data.cell_index;
      wr_data = req_data.height_in;
      if (cmd.c_write) begin
         wr_addr = cur_addr;
         wr_data = (hc_ff >= {2'b00, amount_ff}) ? hc_ff - {2'b00, amount_ff} : 16'd0;
      end else if (cmd.n_write) begin
         wr_addr = nb_idx_ff[k_ff];
         wr_data = nh[16] ? 16'hFFFF : nh[15:0];
      end
      rd_en   = cmd.rd_issue || cmd.c_read || cmd.n_read;
      rd_addr = req_data.cell_index;
      if (cmd.c_read) begin
         rd_addr = cur_addr;
      end else if (cmd.n_read) begin
         rd_addr = nb_addr;
      end
   end

   tes_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff <= 7'd64;
         talus_ff     <= 16'd3277;
      end else if (csr_wr_en) begin
         if (csr_index == REG_GRID_SIDE) begin
            grid_side_ff <= csr_wr_data[6:0];
         end else if (csr_index == REG_TALUS) begin
            talus_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         j_ff   <= '0;
         cnt_ff <= '0;
         k_ff   <= '0;
      end else begin
         if (cmd.sweep_init) begin
            row_ff <= '0;
            col_ff <= '0;
         end
         if (cmd.cell_next) begin
            if ({1'b0, col_ff} == side - 7'd1) begin
               col_ff <= '0;
               row_ff <= row_ff + 6'd1;
            end else begin
               col_ff <= col_ff + 6'd1;
            end
         end
         if (cmd.c_cap) begin
            j_ff   <= '0;
            cnt_ff <= '0;
         end
         if (cmd.n_skip || cmd.n_eval) begin
            j_ff <= j_ff + 4'd1;
         end
         if (cmd.n_eval && take) begin
            cnt_ff <= cnt_ff + 4'd1;
         end
         if (cmd.c_write) begin
            k_ff <= '0;
         end
         if (cmd.n_write) begin
            k_ff <= k_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.c_cap) begin
         hc_ff   <= rd_data;
         dmax_ff <= '0;
         dtot_ff <= '0;
      end
      if (cmd.n_eval && take) begin
         nb_idx_ff[cnt_ff[2:0]] <= nb_addr;
         nb_d_ff[cnt_ff[2:0]]   <= d;
         dtot_ff <= dtot_ff + {3'b000, d};
         if (d > dmax_ff) begin
            dmax_ff <= d;
         end
      end
      if (cmd.calc) begin
         amount_ff <= amt_prod[31:18];
      end
      if (cmd.div_start) begin
         p_ff    <= {16'd0, amount_ff} * {14'd0, nb_d_ff[k_ff]};
         rem_ff  <= '0;
         q_ff    <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         p_ff    <= {p_ff[28:0], 1'b0};
         dcnt_ff <= dcnt_ff + 5'd1;
         if (trial >= {1'b0, dtot_ff}) begin
            rem_ff <= diff[18:0];
            q_ff   <= {q_ff[14:0], 1'b1};
         end else begin
            rem_ff <= trial[18:0];
            q_ff   <= {q_ff[14:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_zero || cmd.out_read || cmd.out_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_zero) begin
         rsp_ff <= '0;
      end else if (cmd.out_read) begin
         rsp_ff.height_out <= rd_data;
         rsp_ff.sweep_done <= 1'b0;
      end else if (cmd.out_done) begin
         rsp_ff.height_out <= '0;
         rsp_ff.sweep_done <= 1'b1;
      end
   end

   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign status.side_zero = (side == 7'd0);
   assign status.nb_in     = row_ok && col_ok;
   assign status.j_end     = (j_ff == 4'd8);
   assign status.cnt_zero  = (cnt_ff == 4'd0);
   assign status.k_last    = ({1'b0, k_ff} == cnt_ff - 4'd1);
   assign status.div_done  = (dcnt_ff == 5'd30);
   assign status.last_cell = ({1'b0, row_ff} == side - 7'd1) &&
                             ({1'b0, col_ff} == side - 7'd1);
endmodule

@@ rtl/thermal_erosion_sweep.sv @@
// Top level of the thermal erosion sweep block.
// The block holds a square height grid and takes one operation per item on
// the req_ channel: load a cell, read a cell, or run one erosion sweep.
// Every item yields exactly one item on the rsp_ channel, held in an
// output register until the receiver takes it.
// A load or no-operation item gives its result in the cycle after acceptance;
// a read registers the store data as its result and holds off new items until then.
// A sweep walks the cells in raster order. Each cell takes a center read,
// up to eight neighbor reads and a step to the next cell, plus a calculate
// and center write step when it sheds material and a divide and write for
// every receiving neighbor, done by the bit-serial share divider over the
// single store port pair.
// The block takes no new item while a sweep runs or while a result waits
// under rsp_stall. Configuration writes on the csr_ port go in at once.
// Synchronous reset sets grid_side to 64 and talus to 3277 and empties the
// result register; the store is not cleared and cells must be loaded first.
module thermal_erosion_sweep import tes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wr_data
);
   cmd_type    cmd;
   status_type status;
   logic       out_busy;

   tes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .out_busy  (out_busy),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   tes_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .out_busy    (out_busy),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );
endmodule
